/* sv/bicb_pkg.sv */
// ----------------------------------------------------------------------------
// bicb_pkg
// Shared widths, codes, types and helpers of the centroid balance unit.
// ----------------------------------------------------------------------------
package bicb_pkg;

    localparam int DEF_MAX_DIMENSION = 256;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int CFG_W       = 9;   // configuration register width
    localparam int CFG_IDX_W   = 1;   // configuration register index width
    localparam int CODE_W      = 2;   // pixel code width
    localparam int COUNT_W     = 17;  // pixel counters
    localparam int SUM_W       = 24;  // coordinate sums
    localparam int OUT_W       = 17;  // balance outputs
    localparam int DIM_LIMIT_W = 13;  // holds the largest supported dimension
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] PIX_FOREGROUND = 2'd1;
    localparam logic [CODE_W-1:0] PIX_HOLE       = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd1;

    // Accumulated totals of one finished image
    typedef struct packed {
        logic [COUNT_W-1:0] fg_count;
        logic [SUM_W-1:0]   fg_row_sum;
        logic [SUM_W-1:0]   fg_col_sum;
        logic [COUNT_W-1:0] hole_count;
        logic [SUM_W-1:0]   hole_row_sum;
        logic [CFG_W-1:0]   height;
        logic [CFG_W-1:0]   width;
        logic               no_holes;
    } img_sums_t;

    typedef enum logic [1:0] {
        OP_VERT,
        OP_HORZ,
        OP_HOLE
    } bal_op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_START,
        B_WAIT,
        B_NEXT,
        B_OUT
    } back_state_t;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_LIMIT_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                      input int unsigned max_dim);
        logic [DIM_LIMIT_W-1:0] ext;
        logic [DIM_LIMIT_W-1:0] lim;
        logic [DIM_LIMIT_W-1:0] res;
        ext = DIM_LIMIT_W'(v);
        lim = DIM_LIMIT_W'(max_dim);
        if (ext == '0)
            res = DIM_LIMIT_W'(1);
        else if (ext > lim)
            res = lim;
        else
            res = ext;
        return res;
    endfunction

endpackage

/* sv/bicb_if.sv */
// ----------------------------------------------------------------------------
// bicb_if
// Valid/ready channels for pixel and result transactions.
// ----------------------------------------------------------------------------
interface pixel_if
    import bicb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] pixel_code;
    logic              no_holes;

    modport source (output valid, output pixel_code, output no_holes, input ready);
    modport sink   (input valid, input pixel_code, input no_holes, output ready);
endinterface

interface result_if
    import bicb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] vertical_balance;
    logic [OUT_W-1:0] horizontal_balance;
    logic [OUT_W-1:0] hole_balance;
    logic             foreground_empty;
    logic             hole_empty;

    modport source (output valid, output vertical_balance, output horizontal_balance,
                    output hole_balance, output foreground_empty, output hole_empty,
                    input ready);
    modport sink   (input valid, input vertical_balance, input horizontal_balance,
                    input hole_balance, input foreground_empty, input hole_empty,
                    output ready);
endinterface

/* sv/bicb_front.sv */
// ----------------------------------------------------------------------------
// bicb_front
// Raster position tracking and per-image accumulation of pixel statistics.
// ----------------------------------------------------------------------------
module bicb_front
    import bicb_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pixel_if.sink                pixels,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 push,
    output img_sums_t            push_data,
    input  logic                 full
);

    localparam int POS_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   col_reg;
    logic [COUNT_W-1:0] fg_cnt_reg,   fg_cnt_next;
    logic [SUM_W-1:0]   fg_rsum_reg,  fg_rsum_next;
    logic [SUM_W-1:0]   fg_csum_reg,  fg_csum_next;
    logic [COUNT_W-1:0] hl_cnt_reg,   hl_cnt_next;
    logic [SUM_W-1:0]   hl_rsum_reg,  hl_rsum_next;

    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] w_eff;
    logic             last_col;
    logic             last_row;
    logic             accept;

    assign pixels.ready = !full;
    assign accept       = pixels.valid && pixels.ready;

    assign h_eff    = DIM_W'(eff_dim(height_reg, MAX_DIMENSION));
    assign w_eff    = DIM_W'(eff_dim(width_reg, MAX_DIMENSION));
    // a position past the end (dimension shrunk mid-image) counts as the last
    assign last_col = DIM_W'(col_reg) >= (w_eff - DIM_W'(1));
    assign last_row = DIM_W'(row_reg) >= (h_eff - DIM_W'(1));

    always_comb
    begin
        fg_cnt_next  = fg_cnt_reg;
        fg_rsum_next = fg_rsum_reg;
        fg_csum_next = fg_csum_reg;
        hl_cnt_next  = hl_cnt_reg;
        hl_rsum_next = hl_rsum_reg;
        if (pixels.pixel_code == PIX_FOREGROUND)
        begin
            fg_cnt_next  = fg_cnt_reg + COUNT_W'(1);
            fg_rsum_next = fg_rsum_reg + SUM_W'(row_reg);
            fg_csum_next = fg_csum_reg + SUM_W'(col_reg);
        end
        else if (pixels.pixel_code == PIX_HOLE)
        begin
            hl_cnt_next  = hl_cnt_reg + COUNT_W'(1);
            hl_rsum_next = hl_rsum_reg + SUM_W'(row_reg);
        end
    end

    // snapshot includes the last pixel's own contribution
    always_comb
    begin
        push_data.fg_count     = fg_cnt_next;
        push_data.fg_row_sum   = fg_rsum_next;
        push_data.fg_col_sum   = fg_csum_next;
        push_data.hole_count   = hl_cnt_next;
        push_data.hole_row_sum = hl_rsum_next;
        push_data.height       = height_reg;
        push_data.width        = width_reg;
        push_data.no_holes     = pixels.no_holes;
    end

    assign push = accept && last_col && last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= CFG_W'(1);
            width_reg  <= CFG_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            fg_cnt_reg  <= '0;
            fg_rsum_reg <= '0;
            fg_csum_reg <= '0;
            hl_cnt_reg  <= '0;
            hl_rsum_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col && last_row)
            begin
                row_reg     <= '0;
                col_reg     <= '0;
                fg_cnt_reg  <= '0;
                fg_rsum_reg <= '0;
                fg_csum_reg <= '0;
                hl_cnt_reg  <= '0;
                hl_rsum_reg <= '0;
            end
            else
            begin
                fg_cnt_reg  <= fg_cnt_next;
                fg_rsum_reg <= fg_rsum_next;
                fg_csum_reg <= fg_csum_next;
                hl_cnt_reg  <= hl_cnt_next;
                hl_rsum_reg <= hl_rsum_next;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end
        end
    end

endmodule

/* sv/bicb_fifo.sv */
// ----------------------------------------------------------------------------
// bicb_fifo
// Short queue of finished image totals between accumulator and divider side.
// ----------------------------------------------------------------------------
module bicb_fifo
    import bicb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  img_sums_t push_data,
    output logic      full,
    input  logic      pop,
    output img_sums_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    img_sums_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
                                    count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* sv/bicb_div.sv */
// ----------------------------------------------------------------------------
// bicb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bicb_div
    import bicb_pkg::*;
#(
    parameter int NUM_W = SUM_W + 2 + DEF_FRACTION_BITS,
    parameter int DEN_W = COUNT_W + 1 + DIM_LIMIT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] den_ext;
    logic           fits;

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign den_ext   = {1'b0, den_reg};
    assign fits      = rem_shift >= den_ext;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so its top bit is always clear
            rem_reg <= fits ? DEN_W'(rem_shift - den_ext) : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* sv/bicb_back.sv */
// ----------------------------------------------------------------------------
// bicb_back
// Per-image balance computation through one shared divider, result register.
// ----------------------------------------------------------------------------
module bicb_back
    import bicb_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  img_sums_t pop_data,
    input  logic      empty,
    output logic      pop,
    result_if.source  results
);

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int BASE_W = SUM_W + 2;
    localparam int NUM_W  = BASE_W + FRACTION_BITS;
    localparam int DEN_W  = COUNT_W + 1 + DIM_W;

    localparam logic [NUM_W-1:0] ONE_FULL = NUM_W'(1) << FRACTION_BITS;
    localparam logic [OUT_W-1:0] ONE_Q    = ONE_FULL[OUT_W-1:0];

    back_state_t state_reg, state_next;
    bal_op_t     op_reg;
    img_sums_t   ent_reg;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [OUT_W-1:0] vert_reg;
    logic [OUT_W-1:0] horz_reg;
    logic [OUT_W-1:0] hole_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_vert_reg;
    logic [OUT_W-1:0] out_horz_reg;
    logic [OUT_W-1:0] out_hole_reg;
    logic             out_fg_empty_reg;
    logic             out_hole_empty_reg;

    logic [SUM_W-1:0]   op_sum;
    logic [COUNT_W-1:0] op_cnt;
    logic [DIM_W-1:0]   op_dim;
    logic               op_no_holes;
    logic               op_skip;
    logic [BASE_W-1:0]  base;
    logic [NUM_W-1:0]   num_calc;
    logic [DEN_W-1:0]   den_calc;

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    logic             out_load;
    logic             res_wr;
    logic [OUT_W-1:0] res_val;

    // operand selection for the balance in hand
    always_comb
    begin
        op_sum = ent_reg.fg_row_sum;
        op_cnt = ent_reg.fg_count;
        op_dim = DIM_W'(eff_dim(ent_reg.height, MAX_DIMENSION));
        unique case (op_reg)
            OP_VERT:
            begin
                op_sum = ent_reg.fg_row_sum;
                op_cnt = ent_reg.fg_count;
                op_dim = DIM_W'(eff_dim(ent_reg.height, MAX_DIMENSION));
            end
            OP_HORZ:
            begin
                op_sum = ent_reg.fg_col_sum;
                op_cnt = ent_reg.fg_count;
                op_dim = DIM_W'(eff_dim(ent_reg.width, MAX_DIMENSION));
            end
            OP_HOLE:
            begin
                op_sum = ent_reg.hole_row_sum;
                op_cnt = ent_reg.hole_count;
                op_dim = DIM_W'(eff_dim(ent_reg.height, MAX_DIMENSION));
            end
            default: ;
        endcase
    end

    assign op_no_holes = (op_reg == OP_HOLE) && ent_reg.no_holes;
    assign op_skip     = op_no_holes || (op_cnt == '0);
    // (2*sum + count) * 2^F over 2*count*dim
    assign base        = BASE_W'({op_sum, 1'b0}) + BASE_W'(op_cnt);
    assign num_calc    = {base, {FRACTION_BITS{1'b0}}};
    assign den_calc    = DEN_W'({op_cnt, 1'b0}) * DEN_W'(op_dim);

    bicb_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        res_wr     = 1'b0;
        res_val    = div_quo[OUT_W-1:0];
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                if (op_skip)
                begin
                    res_wr     = 1'b1;
                    res_val    = op_no_holes ? ONE_Q : '0;
                    state_next = B_NEXT;
                end
                else
                begin
                    state_next = B_START;
                end
            end
            B_START:
            begin
                div_start  = 1'b1;
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (div_done)
                begin
                    res_wr     = 1'b1;
                    state_next = B_NEXT;
                end
            end
            B_NEXT:
            begin
                state_next = (op_reg == OP_HOLE) ? B_OUT : B_LOAD;
            end
            B_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_VERT;
        end
        else if (pop)
        begin
            op_reg <= OP_VERT;
        end
        else if (state_reg == B_NEXT)
        begin
            unique case (op_reg)
                OP_VERT: op_reg <= OP_HORZ;
                OP_HORZ: op_reg <= OP_HOLE;
                default: op_reg <= OP_VERT;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= pop_data;
        if (state_reg == B_LOAD)
        begin
            num_reg <= num_calc;
            den_reg <= den_calc;
        end
        if (res_wr)
        begin
            unique case (op_reg)
                OP_VERT: vert_reg <= res_val;
                OP_HORZ: horz_reg <= res_val;
                OP_HOLE: hole_reg <= res_val;
                default: ;
            endcase
        end
        if (out_load)
        begin
            out_vert_reg       <= vert_reg;
            out_horz_reg       <= horz_reg;
            out_hole_reg       <= hole_reg;
            out_fg_empty_reg   <= (ent_reg.fg_count == '0);
            out_hole_empty_reg <= !ent_reg.no_holes && (ent_reg.hole_count == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    assign results.valid              = out_valid_reg;
    assign results.vertical_balance   = out_vert_reg;
    assign results.horizontal_balance = out_horz_reg;
    assign results.hole_balance       = out_hole_reg;
    assign results.foreground_empty   = out_fg_empty_reg;
    assign results.hole_empty         = out_hole_empty_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
                                  (state_reg == B_WAIT) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
                                   out_load |=> results.valid)
        else $error("loaded result not presented");

endmodule

/* sv/binary_image_centroid_balance_unit.sv */
// ----------------------------------------------------------------------------
// binary_image_centroid_balance_unit
// Foreground and hole centroid balances of a raster-scanned binary image.
// ----------------------------------------------------------------------------
// Usage
//   pixels  : in raster order, one transaction per cycle while the
//             queue is not full (code 1 foreground, code 3 hole).
//             no_holes is only looked at on the last pixel of an image.
//   results : one transaction per image: vertical/horizontal foreground
//             balance, hole row balance (Q1.FRACTION_BITS, truncated) and
//             the two empty flags. Empty classes give zero and set the
//             flag; under no_holes the hole balance is one, flag clear.
//   cfg_*   : image_height (index 0) and image_width (index 1), written
//             while the unit is idle or between pixels of an image.
// Throughput: one pixel per cycle while the queue is not full. Each
//   image costs the back end up to three serial divisions; a queue
//   of QUEUE_DEPTH image totals decouples the accumulator from the
//   divider, so images of at least ~150 pixels stream without stalls.
//   Shorter images are paced by the divider, a one-bit-per-cycle
//   restoring divider with NUM_W = 26 + FRACTION_BITS quotient bits.
// Reset: height and width return to 1, positions and sums clear, queue
//   and result register empty. A stalled result holds in the output
//   register; pixels keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module binary_image_centroid_balance_unit
    import bicb_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pixel_if.sink                pixels,
    result_if.source             results,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // image totals handed from accumulator to divider side
    img_sums_t push_data;
    img_sums_t pop_data;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    // front end: positions, accumulation, snapshot on the last pixel
    bicb_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    bicb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // back end: three balances through a shared divider, output register
    bicb_back #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .results  (results)
    );

endmodule
